### sv/armwu_pkg.sv
// ----------------------------------------------------------------------------
// armwu_pkg
// Shared types and constants of the atomic read-modify-write unit.
// ----------------------------------------------------------------------------
package armwu_pkg;

  localparam int WORDS_DEFAULT = 256;
  localparam int DATA_W        = 64;
  localparam int HALF_W        = 32;
  localparam int INDEX_W       = 8;
  localparam int KIND_W        = 3;
  // power of two: queue pointers wrap by overflow
  localparam int QUEUE_DEPTH   = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_INC  = 3'd0,
    KIND_DEC  = 3'd1,
    KIND_XCHG = 3'd2,
    KIND_CAS  = 3'd3,
    KIND_FADD = 3'd4,
    KIND_AND  = 3'd5,
    KIND_OR   = 3'd6,
    KIND_XOR  = 3'd7
  } kind_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic               wide;
    logic [INDEX_W-1:0] word_index;
    logic [DATA_W-1:0]  operand;
    logic [DATA_W-1:0]  compare_value;
  } req_t;

  typedef struct packed {
    logic [DATA_W-1:0] result_value;
    logic              written;
  } rsp_t;

  typedef struct packed {
    kind_t              kind;
    logic               wide;
    logic               hit;
    logic [INDEX_W-1:0] word_index;
    logic [DATA_W-1:0]  operand;
    logic [DATA_W-1:0]  compare_value;
  } work_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  function automatic logic [DATA_W-1:0] width_mask(input logic wide);
    width_mask = wide ? {DATA_W{1'b1}} : {{(DATA_W-HALF_W){1'b0}}, {HALF_W{1'b1}}};
  endfunction

endpackage

### sv/armwu_chan.sv
// ----------------------------------------------------------------------------
// armwu_chan
// Valid/ready channel carrying one transaction payload.
// ----------------------------------------------------------------------------
interface armwu_chan #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### sv/armwu_front.sv
// ----------------------------------------------------------------------------
// armwu_front
// Accepts requests, range-checks the index, trims operands to the width.
// ----------------------------------------------------------------------------
module armwu_front #(
  parameter int WORDS = armwu_pkg::WORDS_DEFAULT
) (
  armwu_chan.sink                  req,
  input  armwu_pkg::queue_status_t q_status,
  output logic                     push,
  output armwu_pkg::work_t         push_item
);

  logic [armwu_pkg::DATA_W-1:0] mask;

  assign req.ready = !q_status.full;
  assign push      = req.valid && !q_status.full;
  assign mask      = armwu_pkg::width_mask(req.payload.wide);

  always_comb begin
    push_item.kind          = armwu_pkg::kind_t'(req.payload.kind);
    push_item.wide          = req.payload.wide;
    push_item.hit           = 32'(req.payload.word_index) < WORDS;
    push_item.word_index    = req.payload.word_index;
    push_item.operand       = req.payload.operand & mask;
    push_item.compare_value = req.payload.compare_value & mask;
  end

endmodule

### sv/armwu_queue.sv
// ----------------------------------------------------------------------------
// armwu_queue
// Short FIFO between front and back ends.
// ----------------------------------------------------------------------------
module armwu_queue (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  armwu_pkg::work_t         push_item,
  input  logic                     pop,
  output armwu_pkg::work_t         head,
  output armwu_pkg::queue_status_t status
);

  localparam int PTR_W = (armwu_pkg::QUEUE_DEPTH > 1) ? $clog2(armwu_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(armwu_pkg::QUEUE_DEPTH + 1);

  armwu_pkg::work_t slot [armwu_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign head         = slot[rd_ptr];
  assign status.full  = count == CNT_W'(armwu_pkg::QUEUE_DEPTH);
  assign status.empty = count == '0;

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(armwu_pkg::QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("pop from empty queue");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + CNT_W'(1))
    else $error("push lost");

endmodule

### sv/armwu_back.sv
// ----------------------------------------------------------------------------
// armwu_back
// Reads the target word, applies the operation, writes back, holds result.
// ----------------------------------------------------------------------------
module armwu_back #(
  parameter int WORDS = armwu_pkg::WORDS_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  armwu_pkg::work_t         head,
  input  armwu_pkg::queue_status_t q_status,
  output logic                     pop,
  armwu_chan.source                rsp
);

  localparam int SPAN   = 1 << armwu_pkg::INDEX_W;
  localparam int DEPTH  = (WORDS < SPAN) ? WORDS : SPAN;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DW     = armwu_pkg::DATA_W;
  localparam int HW     = armwu_pkg::HALF_W;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  logic [DW-1:0]     mem [DEPTH];
  logic [DEPTH-1:0]  entry_valid;
  armwu_pkg::work_t  cur;
  logic [DW-1:0]     rd_data;
  logic              rd_live;
  logic              out_valid;
  armwu_pkg::rsp_t   out_data;

  logic [ADDR_W-1:0] head_addr;
  logic [ADDR_W-1:0] cur_addr;
  logic              load;
  logic [DW-1:0]     mask;
  logic [DW-1:0]     full;
  logic [DW-1:0]     old;
  logic [DW-1:0]     addend;
  logic [DW-1:0]     sum;
  logic [DW-1:0]     nv;
  logic [DW-1:0]     merged;
  logic [DW-1:0]     ret;
  logic              wr;

  assign head_addr = head.word_index[ADDR_W-1:0];
  assign cur_addr  = cur.word_index[ADDR_W-1:0];
  assign pop       = (state == S_IDLE) && !q_status.empty;
  assign load      = (state == S_EXEC) && (!out_valid || rsp.ready);

  assign rsp.valid   = out_valid;
  assign rsp.payload = out_data;

  always_comb begin
    mask   = armwu_pkg::width_mask(cur.wide);
    full   = rd_live ? rd_data : '0;
    old    = full & mask;
    case (cur.kind)
      armwu_pkg::KIND_INC: addend = DW'(1);
      armwu_pkg::KIND_DEC: addend = '1;
      default:             addend = cur.operand;
    endcase
    sum = old + addend;
    wr  = cur.hit;
    case (cur.kind)
      armwu_pkg::KIND_INC,
      armwu_pkg::KIND_DEC,
      armwu_pkg::KIND_FADD: nv = sum;
      armwu_pkg::KIND_XCHG: nv = cur.operand;
      armwu_pkg::KIND_CAS: begin
        nv = cur.operand;
        if (old != cur.compare_value) begin
          wr = 1'b0;
        end
      end
      armwu_pkg::KIND_AND:  nv = old & cur.operand;
      armwu_pkg::KIND_OR:   nv = old | cur.operand;
      default:              nv = old ^ cur.operand;
    endcase
    merged = (full & ~mask) | (nv & mask);
    if (cur.kind == armwu_pkg::KIND_INC || cur.kind == armwu_pkg::KIND_DEC) begin
      ret = nv & mask;
    end else begin
      ret = old;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (!q_status.empty) state_next = S_EXEC;
      S_EXEC: if (load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // word store: registered read on pop, write on update
  always_ff @(posedge clk) begin
    if (pop) begin
      rd_data <= mem[head_addr];
    end
    if (load && wr) begin
      mem[cur_addr] <= merged;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur     <= head;
      rd_live <= entry_valid[head_addr];
    end
    if (load) begin
      out_data.result_value <= cur.hit ? ret : '0;
      out_data.written      <= wr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      entry_valid <= '0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (load && wr) begin
        entry_valid[cur_addr] <= 1'b1;
      end
    end
  end

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (load && !cur.hit) |=> (out_data.result_value == '0 && !out_data.written))
    else $error("out-of-range transaction returned data");

  a_narrow_upper: assert property (@(posedge clk) disable iff (rst)
    (load && !cur.wide) |=> out_data.result_value[DW-1:HW] == '0)
    else $error("narrow transaction has upper bits set");

  a_write_marks: assert property (@(posedge clk) disable iff (rst)
    (load && wr) |=> entry_valid[$past(cur_addr)])
    else $error("written entry not marked valid");

  a_miss_nowrite: assert property (@(posedge clk) disable iff (rst)
    (load && !cur.hit) |-> !wr)
    else $error("out-of-range transaction wrote store");

endmodule

### sv/atomic_read_modify_write_unit.sv
// ----------------------------------------------------------------------------
// atomic_read_modify_write_unit
// Atomic increment, decrement, exchange, compare-exchange, fetch-add and
// bitwise operations on a store of 64-bit words.
// ----------------------------------------------------------------------------
// Flow: a request is queued, popped with its word read, then its result is
//   registered once any held response is taken; the next is popped only after
//   that, set by the read-then-update sequence on the single-port word store.
// Reset: synchronous; clears the queue, the response valid flag and the per-word
//   valid bits, so every word reads as zero until written.
module atomic_read_modify_write_unit #(
  parameter int WORDS = armwu_pkg::WORDS_DEFAULT
) (
  input logic       clk,
  input logic       rst,
  armwu_chan.sink   req,
  armwu_chan.source rsp
);

  logic                     push;
  armwu_pkg::work_t         push_item;
  logic                     pop;
  armwu_pkg::work_t         head;
  armwu_pkg::queue_status_t q_status;

  armwu_front #(
    .WORDS(WORDS)
  ) u_front (
    .req       (req),
    .q_status  (q_status),
    .push      (push),
    .push_item (push_item)
  );

  armwu_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  armwu_back #(
    .WORDS(WORDS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_status (q_status),
    .pop      (pop),
    .rsp      (rsp)
  );

endmodule
